// ===== hw/rtl/jpcm_pkg.sv =====
// shared types, constants and modular arithmetic for the jump path counter
package jpcm_pkg;

    localparam int MAX_CITIES_DEF = 1024;
    localparam int JUMP_W         = 10;
    localparam int COUNT_W        = 30;

    localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_JRD,
        S_SRD,
        S_WAYS,
        S_WR,
        S_EMIT
    } t_state;

    // (a - b) mod prime, both operands already reduced
    function automatic logic [COUNT_W-1:0] mod_sub(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] diff;
        diff = {1'b0, a} - {1'b0, b};
        if (diff[COUNT_W]) begin
            diff = diff + {1'b0, PRIME};
        end
        return diff[COUNT_W-1:0];
    endfunction

    // (a + b) mod prime, both operands already reduced
    function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, PRIME}) begin
            sum = sum - {1'b0, PRIME};
        end
        return sum[COUNT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/jump_path_count_mod_prime_unit.sv =====
// top level: jump list loader, backward suffix-sum pass and result register
//
//  channel   direction  handshake           word
//  input     in         i_valid / o_stall   i_jump_length, i_is_last
//  result    out        o_valid / i_stall   o_path_count, o_overflow
//
// loading takes one word per cycle; the word marked last starts the backward pass
// the pass runs the set-up states S_INIT and S_JRD, then for each stored city:
// a jump read, a suffix-sum read at the landing city, then the subtract and the add/write-back,
// all bound by the single read port of each memory
// an overflowed list skips the pass and answers at once
// reset is synchronous and active low; neither memory is cleared
// o_stall stays high from the last word until its result sits in the output register
module jump_path_count_mod_prime_unit #(
    parameter int MAX_CITIES = jpcm_pkg::MAX_CITIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [jpcm_pkg::JUMP_W-1:0]  i_jump_length,
    input  logic                         i_is_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [jpcm_pkg::COUNT_W-1:0] o_path_count,
    output logic                         o_overflow
);

    import jpcm_pkg::*;

    localparam int AW = $clog2(MAX_CITIES);
    localparam int CW = $clog2(MAX_CITIES + 1);
    localparam int FW = ((CW > JUMP_W) ? CW : JUMP_W) + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CITIES);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_c, n_c;
    logic [COUNT_W-1:0] r_next, n_next;
    logic [COUNT_W-1:0] r_ways, n_ways;
    logic               r_far_ok, n_far_ok;
    logic [COUNT_W-1:0] r_res, n_res;
    logic               r_res_ovf, n_res_ovf;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_ovf, n_out_ovf;

    logic               in_acc;
    logic               jump_wr_en;
    logic [AW-1:0]      jump_rd_addr;
    logic [JUMP_W-1:0]  jump_rd_data;
    logic               sum_wr_en;
    logic [CW-1:0]      sum_wr_addr;
    logic [COUNT_W-1:0] sum_wr_data;
    logic [CW-1:0]      sum_rd_addr;
    logic [COUNT_W-1:0] sum_rd_data;
    logic [FW-1:0]      far;
    logic [COUNT_W-1:0] far_sum;
    logic [COUNT_W-1:0] new_sum;
    logic [CW-1:0]      c_dec;

    assign o_stall = (r_state != S_LOAD);
    assign in_acc  = i_valid && !o_stall;

    assign jump_wr_en   = in_acc && (r_count < MAX_CNT);
    assign c_dec        = r_c - CW'(1);
    // in the write-back cycle fetch the jump of the next city down
    assign jump_rd_addr = (r_state == S_WR) ? c_dec[AW-1:0] : r_c[AW-1:0];

    jpcm_ram #(
        .WIDTH (JUMP_W),
        .DEPTH (MAX_CITIES)
    ) u_jump_ram (
        .i_clk     (i_clk),
        .i_wr_en   (jump_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_jump_length),
        .i_rd_addr (jump_rd_addr),
        .o_rd_data (jump_rd_data)
    );

    assign far         = FW'(r_c) + FW'(jump_rd_data) + FW'(1);
    assign sum_rd_addr = far[CW-1:0];
    assign far_sum     = r_far_ok ? sum_rd_data : '0;
    assign new_sum     = mod_add(r_ways, r_next);

    assign sum_wr_en   = (r_state == S_INIT) || (r_state == S_WR);
    assign sum_wr_addr = (r_state == S_INIT) ? r_n : r_c;
    assign sum_wr_data = (r_state == S_INIT) ? COUNT_W'(1) : new_sum;

    jpcm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_CITIES + 1)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sum_wr_en),
        .i_wr_addr (sum_wr_addr),
        .i_wr_data (sum_wr_data),
        .i_rd_addr (sum_rd_addr),
        .o_rd_data (sum_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_c         = r_c;
        n_next      = r_next;
        n_ways      = r_ways;
        n_far_ok    = r_far_ok;
        n_res       = r_res;
        n_res_ovf   = r_res_ovf;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < MAX_CNT) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        if (r_ovf || (r_count == MAX_CNT)) begin
                            n_res     = '0;
                            n_res_ovf = 1'b1;
                            n_state   = S_EMIT;
                        end else begin
                            n_n     = r_count + CW'(1);
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_INIT: begin
                n_next  = COUNT_W'(1);
                n_c     = r_n - CW'(1);
                n_state = S_JRD;
            end
            S_JRD: begin
                n_state = S_SRD;
            end
            S_SRD: begin
                n_far_ok = (far <= FW'(r_n));
                n_state  = S_WAYS;
            end
            S_WAYS: begin
                n_ways  = mod_sub(r_next, far_sum);
                n_state = S_WR;
            end
            S_WR: begin
                n_next = new_sum;
                if (r_c == '0) begin
                    n_res     = r_ways;
                    n_res_ovf = 1'b0;
                    n_state   = S_EMIT;
                end else begin
                    n_c     = c_dec;
                    n_state = S_SRD;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_res;
                    n_out_ovf   = r_res_ovf;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_c         <= n_c;
        r_next      <= n_next;
        r_ways      <= n_ways;
        r_far_ok    <= n_far_ok;
        r_res       <= n_res;
        r_res_ovf   <= n_res_ovf;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_valid      = r_out_valid;
    assign o_path_count = r_out_count;
    assign o_overflow   = r_out_ovf;

    // an overflowed list always reports a zero count
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_path_count == '0))
        else $error("overflow result carries a non-zero count");

    // every reported count is fully reduced
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_path_count < PRIME))
        else $error("path count not reduced modulo the prime");

    // the pass only ever visits stored cities
    a_city_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRD) |-> ((r_c < r_n) && (r_n <= MAX_CNT)))
        else $error("backward pass city index out of range");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("city count beyond store depth");

endmodule

// ===== hw/rtl/jpcm_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
module jpcm_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== test/jump_path_count_mod_prime_unit_tb.sv =====
// self-checking testbench for the jump path counter with bursty input and stalled output
`timescale 1ns / 1ps

module jump_path_count_mod_prime_unit_tb;
    import jpcm_pkg::*;

    localparam int NCITY      = MAX_CITIES_DEF;
    localparam int CYCLE_CAP  = 600000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic [JUMP_W-1:0] jump;
        logic              last;
        bit                drain_first;
    } t_city_word;

    typedef struct packed {
        logic [COUNT_W-1:0] path_count;
        logic               overflow;
    } t_count_result;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [JUMP_W-1:0]    i_jump_length = '0;
    logic                 i_is_last = 1'b0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [COUNT_W-1:0]   o_path_count;
    logic                 o_overflow;

    t_city_word           city_words[$];
    t_count_result        expected_counts[$];

    // current list as the block should hold it
    logic [JUMP_W-1:0]    list_jumps [NCITY];
    int unsigned          list_len = 0;
    bit                   list_overflowed = 1'b0;

    int                   mismatches = 0;
    int                   results_seen = 0;
    int                   cycle_count = 0;
    int                   gap_left = 0;
    int                   burst_left = 0;
    int                   hold_left = 0;
    int                   next_hold_at = 30;
    int                   stall_mode = 0;
    int                   mode_left = 0;

    jump_path_count_mod_prime_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_jump_length (i_jump_length),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_path_count  (o_path_count),
        .o_overflow    (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // ways to reach the target from city 0, built backward over suffix sums
    function automatic logic [COUNT_W-1:0] paths_to_target(input int unsigned n);
        longint unsigned suffix [NCITY+1];
        longint unsigned prime_l;
        longint unsigned ways;
        longint unsigned nxt;
        longint unsigned far_sum;
        int unsigned     far;
        prime_l   = longint'(PRIME);
        ways      = 1;
        suffix[n] = 1;
        for (int c = int'(n) - 1; c >= 0; c--) begin
            nxt     = suffix[c+1];
            far     = c + list_jumps[c] + 1;
            far_sum = (far <= n) ? suffix[far] : 0;
            ways    = (nxt + prime_l - far_sum) % prime_l;
            suffix[c] = (ways + nxt) % prime_l;
        end
        return ways[COUNT_W-1:0];
    endfunction

    task automatic take_city(input logic [JUMP_W-1:0] jump, input logic last);
        t_count_result r;
        if (list_len < NCITY) begin
            list_jumps[list_len] = jump;
            list_len++;
        end else begin
            list_overflowed = 1'b1;
        end
        if (last) begin
            r.overflow   = list_overflowed;
            r.path_count = list_overflowed ? '0 : paths_to_target(list_len);
            expected_counts = {expected_counts, r};
            list_len        = 0;
            list_overflowed = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    function automatic logic [JUMP_W-1:0] pick_jump(input int style, input int len);
        int r;
        r = $urandom_range(0, 7);
        case (style)
            0: return JUMP_W'($urandom_range(0, 4));
            1: return JUMP_W'($urandom_range(0, 1023));
            default: begin
                if (r == 0) return '0;
                if (r == 1) return '1;
                return JUMP_W'($urandom_range(1, len));
            end
        endcase
    endfunction

    task automatic add_list(input int len, input int style, input bit drain);
        t_city_word w;
        for (int k = 0; k < len; k++) begin
            w.jump        = pick_jump(style, len);
            w.last        = (k == len - 1);
            w.drain_first = drain && (k == 0);
            city_words    = {city_words, w};
        end
    endtask

    // sender: bursts of words with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        t_city_word w;
        bit taken;
        bit offer;
        taken = 1'b0;
        offer = 1'b0;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_jump_length <= '0;
            i_is_last     <= 1'b0;
        end else begin
            taken = i_valid && !o_stall;
            if (taken) begin
                take_city(i_jump_length, i_is_last);
            end
            if (!i_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (city_words.size() != 0) begin
                    // a marked word waits until the block has answered everything
                    offer = !(city_words[0].drain_first && expected_counts.size() != 0);
                end
                if (offer) begin
                    w = city_words.pop_front();
                    i_jump_length <= w.jump;
                    i_is_last     <= w.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                i_valid <= offer;
            end
        end
    end

    // receiver: stall pattern changes every so often, with long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (results_seen >= next_hold_at) begin
            next_hold_at += 40;
            hold_left = LONG_HOLD;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode_left  = $urandom_range(16, 96);
                stall_mode = $urandom_range(0, 3);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_count_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
                note_mismatch("result word with none due", 0, o_path_count);
            end else begin
                want = expected_counts.pop_front();
                if (o_path_count !== want.path_count) begin
                    note_mismatch("path_count", want.path_count, o_path_count);
                end
                if (o_overflow !== want.overflow) begin
                    note_mismatch("overflow", want.overflow, o_overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_city_word w;
        int small_words;
        int lists_made;
        int len;
        int d_jumps [23];
        int d_last [23];
        d_jumps = '{0, 1023, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2, 1023, 0, 1023,
                    0, 1023, 1023, 1023, 1023, 1023, 1023, 1023};
        d_last  = '{1, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1,
                    0, 0, 1, 0, 0, 0, 0, 1};
        // single cities, unit and wide jumps, a zero jump mid list and at the start
        for (int k = 0; k < 23; k++) begin
            w.jump        = JUMP_W'(d_jumps[k]);
            w.last        = (d_last[k] != 0);
            w.drain_first = 1'b0;
            city_words    = {city_words, w};
        end
        small_words = 0;
        lists_made  = 0;
        while (small_words < 240 || lists_made < 28) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
            add_list(len, $urandom_range(0, 2), lists_made == 0 || $urandom_range(0, 19) == 0);
            small_words += len;
            lists_made++;
        end
        // one word past a full store
        add_list(NCITY + 1, 1, 1'b1);
        for (int k = 0; k < 10; k++) begin
            add_list($urandom_range(1, 12), $urandom_range(0, 2), 1'b0);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (city_words.size() != 0 || i_valid || expected_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3 * NCITY + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
